[rtl/smf_pkg.sv]
// Package: shared types and constants of the sliding window median filter.
`timescale 1ns / 1ps

package smf_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int CFG_BITS    = 6;
    localparam logic [CFG_BITS-1:0] CFG_RESET = 6'd10;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          frame_end;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] median;
        logic                          run_last;
        logic                          frame_last;
    } t_out;

    // broadcast to every cell of the sorted chain
    typedef struct packed {
        logic                          load;  // preset whole chain to x
        logic                          ins;   // drop oldest, insert x
        logic signed [SAMPLE_BITS-1:0] x;
    } t_cell_ctl;

    typedef enum logic {
        ST_RUN,
        ST_FLUSH
    } t_state;

endpackage

[rtl/smf_cell.sv]
// One cell of the sorted chain: holds a sample and its age in the window.
`timescale 1ns / 1ps

module smf_cell #(
    parameter int IDX = 0,
    parameter int NW  = 6
) (
    input  logic                                  i_clk,
    input  smf_pkg::t_cell_ctl                    i_ctl,
    input  logic [NW-1:0]                         i_n,
    input  logic signed [smf_pkg::SAMPLE_BITS-1:0] i_left_v,
    input  logic [NW-1:0]                         i_left_age,
    input  logic                                  i_left_le,
    input  logic signed [smf_pkg::SAMPLE_BITS-1:0] i_right_v,
    input  logic [NW-1:0]                         i_right_age,
    input  logic                                  i_right_le,
    input  logic                                  i_del_left,
    output logic signed [smf_pkg::SAMPLE_BITS-1:0] o_v,
    output logic [NW-1:0]                         o_age,
    output logic                                  o_le,
    output logic                                  o_del_seen
);

    logic signed [smf_pkg::SAMPLE_BITS-1:0] r_v, n_v;
    logic [NW-1:0] r_age, n_age;
    logic w_le, w_in_win, w_last, w_del, w_l, w_r;

    assign w_le     = $signed(r_v) <= $signed(i_ctl.x);
    assign w_in_win = NW'(IDX) < i_n;
    assign w_last   = NW'(IDX) == (i_n - NW'(1));
    assign w_del    = w_in_win && (r_age == (i_n - NW'(1)));
    // left neighbour not above x, right neighbour above x (chain ends count as such)
    assign w_l      = (IDX == 0) || i_left_le;
    assign w_r      = w_last || !i_right_le;

    assign o_v        = r_v;
    assign o_age      = r_age;
    assign o_le       = w_le;
    assign o_del_seen = i_del_left | w_del;

    always_comb begin
        n_v   = r_v;
        n_age = r_age;
        if (i_ctl.load) begin
            n_v   = i_ctl.x;
            n_age = NW'(IDX);
        end else if (i_ctl.ins && w_in_win) begin
            if (i_del_left) begin
                // gap is to the left: pull from the right or take x
                if (!w_r) begin
                    n_v   = i_right_v;
                    n_age = i_right_age + NW'(1);
                end else if (w_le) begin
                    n_v   = i_ctl.x;
                    n_age = '0;
                end else begin
                    n_age = r_age + NW'(1);
                end
            end else if (w_del) begin
                if (!w_r) begin
                    n_v   = i_right_v;
                    n_age = i_right_age + NW'(1);
                end else if (w_l) begin
                    n_v   = i_ctl.x;
                    n_age = '0;
                end else begin
                    n_v   = i_left_v;
                    n_age = i_left_age + NW'(1);
                end
            end else begin
                // gap is to the right: push right past x
                if (w_le) begin
                    n_age = r_age + NW'(1);
                end else if (w_l) begin
                    n_v   = i_ctl.x;
                    n_age = '0;
                end else begin
                    n_v   = i_left_v;
                    n_age = i_left_age + NW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_v   <= n_v;
        r_age <= n_age;
    end

endmodule

[rtl/sliding_window_median_filter.sv]
// Top level: running median over a framed sample stream using a sorted cell chain.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+----------------------------
//   in      | input     | i_in_valid / o_in_ready  | i_in  (sample, frame_end)
//   out     | output    | o_out_valid / i_out_ready| o_out (median, run_last,
//           |           |                          |        frame_last)
//   cfg     | input     | i_cfg_we                 | i_cfg_data (window size)
//
// A sample is taken every cycle while results drain; each sample moves the
// sorted chain by one insert/delete step, and its median is then registered in
// the output register. A stalled output holds the chain while a result waits in it.
// A frame_end sample is followed by a flush of N-M steps through the same chain,
// one per cycle, though a step with a result waits for a free output; a frame
// shorter than N-M spends its first steps padding the chain without a result.
// o_in_ready stays low for the whole flush. Synchronous active-low reset clears
// control state and the output valid; the window size register resets to 10.
`timescale 1ns / 1ps

module sliding_window_median_filter #(
    parameter int MAX_WINDOW = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  smf_pkg::t_in                         i_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output smf_pkg::t_out                        o_out,
    input  logic                                 i_cfg_we,
    input  logic [smf_pkg::CFG_BITS-1:0]         i_cfg_data
);

    localparam int NW = $clog2(MAX_WINDOW + 1);
    localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SB = smf_pkg::SAMPLE_BITS;

    // control state
    smf_pkg::t_state r_state, n_state;
    logic [smf_pkg::CFG_BITS-1:0] r_cfg;
    logic [NW-1:0] r_win, n_win;       // window size latched for this frame
    logic [NW-1:0] r_fcnt, n_fcnt;     // samples in frame, saturating
    logic [NW-1:0] r_silent, n_silent; // flush steps that give no result
    logic [NW-1:0] r_cnt, n_cnt;       // flush results still to give
    logic          r_emit, n_emit;     // a result waits in the chain
    logic          r_ovalid, n_ovalid;
    logic signed [SB-1:0] r_newest, n_newest;
    smf_pkg::t_out r_out, n_out;

    // chain wiring
    smf_pkg::t_cell_ctl w_ctl;
    logic signed [SB-1:0] w_v [MAX_WINDOW];
    logic [NW-1:0]        w_age [MAX_WINDOW];
    logic                 w_le [MAX_WINDOW];
    logic                 w_dseen [MAX_WINDOW];

    logic [smf_pkg::CFG_BITS:0] w_cfg_ext;
    logic [NW-1:0] w_eff, w_n_cur, w_lagp, w_f_next, w_cnt0, w_mid;
    logic          w_out_free, w_in_ready, w_acc;
    logic signed [SB-1:0] w_median;

    // effective window: zero means one, clamp to the chain length
    assign w_cfg_ext = {1'b0, r_cfg};
    always_comb begin
        if (r_cfg == '0) begin
            w_eff = NW'(1);
        end else if (w_cfg_ext > (smf_pkg::CFG_BITS+1)'(MAX_WINDOW)) begin
            w_eff = NW'(MAX_WINDOW);
        end else begin
            w_eff = NW'(w_cfg_ext);
        end
    end

    assign w_n_cur  = (r_fcnt == '0) ? w_eff : r_win;
    assign w_lagp   = w_n_cur - (w_n_cur >> 1);
    assign w_f_next = (r_fcnt == NW'(MAX_WINDOW)) ? r_fcnt : r_fcnt + NW'(1);
    assign w_cnt0   = (w_f_next < w_lagp) ? w_f_next : w_lagp;

    assign w_mid    = r_win >> 1;
    assign w_median = w_v[w_mid[IW-1:0]];

    assign w_out_free = !r_ovalid || i_out_ready;
    assign w_in_ready = (r_state == smf_pkg::ST_RUN) && (!r_emit || w_out_free);
    assign w_acc      = i_in_valid && w_in_ready;

    // Chain control: preset on the first sample of a frame, otherwise insert the
    // new sample, or during flush a copy of the newest one (end padding).
    always_comb begin
        w_ctl.load = w_acc && (r_fcnt == '0);
        w_ctl.ins  = (w_acc && (r_fcnt != '0))
                  || ((r_state == smf_pkg::ST_FLUSH)
                      && ((r_silent != '0) || (w_out_free && (r_cnt != NW'(1)))));
        w_ctl.x    = w_acc ? i_in.sample : r_newest;
    end

    genvar k;
    generate
        for (k = 0; k < MAX_WINDOW; k++) begin : g_cell
            logic signed [SB-1:0] w_lv, w_rv;
            logic [NW-1:0]        w_la, w_ra;
            logic                 w_lle, w_rle, w_dl;
            if (k == 0) begin : g_first
                assign w_lv  = '0;
                assign w_la  = '0;
                assign w_lle = 1'b1;
                assign w_dl  = 1'b0;
            end else begin : g_mid_l
                assign w_lv  = w_v[k-1];
                assign w_la  = w_age[k-1];
                assign w_lle = w_le[k-1];
                assign w_dl  = w_dseen[k-1];
            end
            if (k == MAX_WINDOW - 1) begin : g_last
                assign w_rv  = '0;
                assign w_ra  = '0;
                assign w_rle = 1'b0;
            end else begin : g_mid_r
                assign w_rv  = w_v[k+1];
                assign w_ra  = w_age[k+1];
                assign w_rle = w_le[k+1];
            end
            smf_cell #(
                .IDX(k),
                .NW (NW)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_n        (r_win),
                .i_left_v   (w_lv),
                .i_left_age (w_la),
                .i_left_le  (w_lle),
                .i_right_v  (w_rv),
                .i_right_age(w_ra),
                .i_right_le (w_rle),
                .i_del_left (w_dl),
                .o_v        (w_v[k]),
                .o_age      (w_age[k]),
                .o_le       (w_le[k]),
                .o_del_seen (w_dseen[k])
            );
        end
    endgenerate

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_win    = r_win;
        n_fcnt   = r_fcnt;
        n_silent = r_silent;
        n_cnt    = r_cnt;
        n_emit   = r_emit;
        n_newest = r_newest;
        n_out    = r_out;
        n_ovalid = i_out_ready ? 1'b0 : r_ovalid;

        unique case (r_state)
            smf_pkg::ST_RUN: begin
                // drain the result of the previous sample
                if (r_emit && w_out_free) begin
                    n_out.median     = w_median;
                    n_out.run_last   = 1'b1;
                    n_out.frame_last = 1'b0;
                    n_ovalid         = 1'b1;
                    n_emit           = 1'b0;
                end
                if (w_acc) begin
                    n_newest = i_in.sample;
                    n_fcnt   = w_f_next;
                    n_win    = w_n_cur;
                    if (i_in.frame_end) begin
                        n_state  = smf_pkg::ST_FLUSH;
                        n_cnt    = w_cnt0;
                        n_silent = w_lagp - w_cnt0;
                        n_emit   = 1'b0;
                    end else begin
                        n_emit = (w_f_next >= w_lagp);
                    end
                end
            end
            smf_pkg::ST_FLUSH: begin
                if (r_silent != '0) begin
                    n_silent = r_silent - NW'(1);
                end else if (w_out_free) begin
                    n_out.median     = w_median;
                    n_out.run_last   = (r_cnt == NW'(1));
                    n_out.frame_last = (r_cnt == NW'(1));
                    n_ovalid         = 1'b1;
                    if (r_cnt == NW'(1)) begin
                        // frame done: next sample presets the chain
                        n_state = smf_pkg::ST_RUN;
                        n_fcnt  = '0;
                    end else begin
                        n_cnt = r_cnt - NW'(1);
                    end
                end
            end
            default: n_state = smf_pkg::ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= smf_pkg::ST_RUN;
            r_cfg    <= smf_pkg::CFG_RESET;
            r_win    <= NW'(1);
            r_fcnt   <= '0;
            r_silent <= '0;
            r_cnt    <= '0;
            r_emit   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            r_win    <= n_win;
            r_fcnt   <= n_fcnt;
            r_silent <= n_silent;
            r_cnt    <= n_cnt;
            r_emit   <= n_emit;
            r_ovalid <= n_ovalid;
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        r_newest <= n_newest;
        r_out    <= n_out;
    end

    assign o_in_ready  = w_in_ready;
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

endmodule

[rtl/smf_checker.sv]
// Checker: port-level properties of the median filter, bound to the top level.
`timescale 1ns / 1ps

module smf_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input smf_pkg::t_in  i_in,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input smf_pkg::t_out o_out
);

    // no result straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result changed");

    // end of frame is also end of the run
    a_frame_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out.frame_last || o_out.run_last))
        else $error("frame_last without run_last");

    // flush blocks input after the frame's last sample
    a_flush_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in.frame_end) |=> !o_in_ready)
        else $error("input taken during flush");

endmodule

bind sliding_window_median_filter smf_checker u_smf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .i_in       (i_in),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out      (o_out)
);

[tb/testbench.sv]
// Testbench: self-checking random and directed test of the sliding window median filter.
`timescale 1ns / 1ps

module testbench;

    localparam int SB           = smf_pkg::SAMPLE_BITS;
    localparam int CB           = smf_pkg::CFG_BITS;
    localparam int MAX_WIN      = 32;
    localparam int DRAIN_CYCLES = 60;    // longest flush plus output stage, with margin
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off to back the block up
    localparam int QUIET_LIMIT  = 2000;  // cycles without any transfer before giving up
    localparam int PHASE_ITEMS  = 19;
    localparam int LONG_FRAME   = 40;    // longer than the widest window

    // ------------------------------------------------------------------
    // Clock, reset and the signals to the block
    // ------------------------------------------------------------------
    logic            clk      = 1'b0;
    logic            rst_n    = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_ready;
    smf_pkg::t_in    in_item  = '0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    smf_pkg::t_out   out_item;
    logic            cfg_we   = 1'b0;
    logic [CB-1:0]   cfg_data = '0;

    sliding_window_median_filter #(
        .MAX_WINDOW (MAX_WIN)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shared state between stimulus, driver and monitor
    // ------------------------------------------------------------------
    smf_pkg::t_in  pending_samples[$];    // items waiting to be offered
    smf_pkg::t_out expected_medians[$];   // results predicted but not yet seen
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    bit   hold_req      = 1'b0;
    bit   hold_done     = 1'b0;
    int   hold_left     = 0;
    int   mismatch_count = 0;

    // ------------------------------------------------------------------
    // Median predictor: own copy of the window register and frame state
    // ------------------------------------------------------------------
    logic [CB-1:0]          win_reg = smf_pkg::CFG_RESET;
    logic signed [SB-1:0]   ring_q [MAX_WIN];
    int unsigned            ring_wr    = 0;
    int unsigned            taken_cnt  = 0;    // samples of this frame, saturating
    int unsigned            latched_n  = 0;
    logic signed [SB-1:0]   first_sample = '0;

    initial begin
        for (int i = 0; i < MAX_WIN; i++) ring_q[i] = '0;
    end

    // Sample at a given age (0 = newest); anything older than the frame start
    // repeats the first sample of the frame.
    function automatic logic signed [SB-1:0] sample_at_age(int unsigned age);
        if (age >= taken_cnt || age >= MAX_WIN) return first_sample;
        return ring_q[(ring_wr + 2 * MAX_WIN - 1 - age) % MAX_WIN];
    endfunction

    // Median of the window whose result is the pend-th one still owed.
    function automatic logic signed [SB-1:0] window_median(int unsigned pend,
                                                           int unsigned n);
        logic signed [SB-1:0] w [MAX_WIN];
        int unsigned mid, lt, le;
        int age, k, j;
        mid = n / 2;
        for (k = 0; k < int'(n); k++) begin
            age = int'(pend) - 1 - (k - int'(mid));
            if (age < 0) age = 0;   // past the newest sample: repeat the newest
            w[k] = sample_at_age(unsigned'(age));
        end
        // rank select: the element with mid below it and mid not above it
        for (k = 0; k < int'(n); k++) begin
            lt = 0;
            le = 0;
            for (j = 0; j < int'(n); j++) begin
                if (w[j] < w[k]) lt++;
                if (w[j] <= w[k]) le++;
            end
            if (lt <= mid && mid < le) return w[k];
        end
        return w[0];
    endfunction

    function automatic void push_median(logic signed [SB-1:0] m, bit rl, bit fl);
        smf_pkg::t_out r;
        r.median     = m;
        r.run_last   = rl;
        r.frame_last = fl;
        expected_medians.push_back(r);
    endfunction

    // Advance the predictor by one accepted sample and queue what it causes.
    function automatic void take_sample(smf_pkg::t_in it);
        int unsigned n, lag_plus, cnt;
        if (taken_cnt == 0) begin
            // latch the window size at the first sample of the frame
            first_sample = it.sample;
            n = win_reg;
            if (n == 0) n = 1;
            if (n > MAX_WIN) n = MAX_WIN;
            latched_n = n;
        end
        n = latched_n;
        ring_q[ring_wr] = it.sample;
        ring_wr = (ring_wr + 1) % MAX_WIN;
        if (taken_cnt < 65535) taken_cnt++;
        lag_plus = n - n / 2;

        if (!it.frame_end) begin
            if (taken_cnt >= lag_plus) push_median(window_median(lag_plus, n), 1'b1, 1'b0);
            return;
        end

        // frame end: flush everything still owed, then clear for the next frame
        cnt = (taken_cnt < lag_plus) ? taken_cnt : lag_plus;
        while (cnt > 0) begin
            push_median(window_median(cnt, n), cnt == 1, cnt == 1);
            cnt--;
        end
        for (int i = 0; i < MAX_WIN; i++) ring_q[i] = '0;
        ring_wr      = 0;
        taken_cnt    = 0;
        first_sample = '0;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting: print one line and count
    // ------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver: offer queued samples, hold valid and payload until transfer
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) take_sample(in_item);
            // only move on once the current item has gone (or none is offered)
            if (!in_valid || in_ready) begin
                if (pending_samples.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    in_item  <= pending_samples.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result transfer against the oldest prediction,
    // and drive ready with random stalls and one long hold-off
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        smf_pkg::t_out want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_medians.size() == 0) begin
                    report_mismatch($sformatf("unexpected result median=%0d run_last=%0b",
                                              out_item.median, out_item.run_last));
                end else begin
                    want = expected_medians.pop_front();
                    if (out_item.median !== want.median)
                        report_mismatch($sformatf("median %0d, expected %0d",
                                                  out_item.median, want.median));
                    if (out_item.run_last !== want.run_last)
                        report_mismatch($sformatf("run_last %b, expected %b",
                                                  out_item.run_last, want.run_last));
                    if (out_item.frame_last !== want.frame_last)
                        report_mismatch($sformatf("frame_last %b, expected %b",
                                                  out_item.frame_last, want.frame_last));
                end
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                // hold off long enough for the block to fill and stall its input
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if nothing transfers for too long
    // ------------------------------------------------------------------
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_sample(logic signed [SB-1:0] v, bit last);
        smf_pkg::t_in it;
        it.sample    = v;
        it.frame_end = last;
        pending_samples.push_back(it);
    endtask

    // Mix of extremes, near-ties and fully random values.
    function automatic logic signed [SB-1:0] pick_sample();
        case ($urandom_range(7, 0))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return SB'($signed($urandom_range(6, 0)) - 3);
            3:       return $urandom_range(1, 0) ? 16'sh0000 : 16'shFFFF;
            default: return SB'($urandom);
        endcase
    endfunction

    // Queue one frame; an open frame has no closing sample.
    task automatic queue_frame(int len, bit closed);
        for (int i = 0; i < len; i++)
            queue_sample(pick_sample(), closed && (i == len - 1));
    endtask

    // Wait until the driver is empty and every prediction has been met,
    // then let the block finish any work that yields no result.
    task automatic wait_idle();
        do @(negedge clk);
        while (pending_samples.size() != 0 || in_valid || expected_medians.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_window(logic [CB-1:0] v);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        win_reg   = v;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int plan [10];
        int added, len;

        plan = '{1, 32, 0, 63, 2, 7, 16, 10, 3, 0};
        plan[9] = $urandom_range(63, 0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset window size: extremes, ties, a one-sample
        // frame and a frame shorter than the lag.
        send_idle_pct = 15;
        recv_idle_pct = 74;
        queue_sample(16'sh7FFF, 1'b0);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh0000, 1'b0);
        queue_sample(16'shFFFF, 1'b0);
        queue_sample(16'sh0001, 1'b0);
        queue_sample(16'sh7FFF, 1'b0);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sd100, 1'b0);
        queue_sample(16'sd100, 1'b0);
        queue_sample(16'sd100, 1'b0);
        queue_sample(-16'sd5, 1'b0);
        queue_sample(16'sd7, 1'b1);
        queue_sample(16'sh8000, 1'b1);
        queue_sample(16'sd5, 1'b0);
        queue_sample(-16'sd5, 1'b1);
        for (int i = 0; i < 8; i++) queue_sample(16'sd3, i == 7);

        // Random phases, each under its own window size. The register is
        // written only once the block has gone quiet.
        for (int p = 0; p < 10; p++) begin
            wait_idle();
            write_window(plan[p][CB-1:0]);
            if (p < 4) begin
                send_idle_pct = 15;
                recv_idle_pct = 74;
            end else if (p < 7) begin
                send_idle_pct = 74;
                recv_idle_pct = 15;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p == 7) hold_req = 1'b1;

            added = 0;
            while (added < PHASE_ITEMS) begin
                len = ($urandom_range(3, 0) == 0) ? $urandom_range(4, 1)
                                                  : $urandom_range(40, 5);
                if (len > PHASE_ITEMS - added) len = PHASE_ITEMS - added;
                queue_frame(len, 1'b1);
                added += len;
            end
            // leave a frame open so the next write lands mid-frame and must
            // only take effect at the following frame
            if (p == 4) queue_frame(6, 1'b0);
        end

        // Long frame at the widest window: slide past the full chain and
        // saturate the frame counter.
        wait_idle();
        write_window(CB'(MAX_WIN));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_frame(LONG_FRAME, 1'b1);

        wait_idle();
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[sliding_window_median_filter.f]
rtl/smf_pkg.sv
rtl/smf_cell.sv
rtl/sliding_window_median_filter.sv
rtl/smf_checker.sv
tb/testbench.sv
